[src/dqr_pkg.sv]
// Package for the DNS query responder: payload structs, parse phase codes,
// answer kinds and the constant byte tables.
// No dependencies.
package dqr_pkg;

    // Input item: one query byte plus end-of-datagram mark
    typedef struct packed {
        logic [7:0] query_byte;
        logic       datagram_end;
    } query_t;

    // Result item: one reply byte with last mark and status
    typedef struct packed {
        logic [7:0] reply_byte;
        logic       reply_last;
        logic [1:0] reply_status;
    } reply_t;

    // Parse phases
    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_NAME    = 3'd1;
    localparam logic [2:0] PH_LABEL   = 3'd2;
    localparam logic [2:0] PH_TYPE    = 3'd3;
    localparam logic [2:0] PH_CLASS   = 3'd4;
    localparam logic [2:0] PH_DISCARD = 3'd5;

    // Reply status codes
    localparam logic [1:0] ST_ANSWERED    = 2'd0;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
    localparam logic [1:0] ST_MALFORMED   = 2'd2;

    // Query types served
    localparam logic [15:0] QTYPE_A     = 16'd1;
    localparam logic [15:0] QTYPE_AAAA  = 16'd28;
    localparam logic [15:0] QTYPE_CNAME = 16'd5;

    // Answer kinds
    localparam logic [1:0] ANS_A     = 2'd0;
    localparam logic [1:0] ANS_AAAA  = 2'd1;
    localparam logic [1:0] ANS_CNAME = 2'd2;

    // Index of the final answer byte for each kind
    localparam logic [4:0] LAST_A     = 5'd15;
    localparam logic [4:0] LAST_AAAA  = 5'd27;
    localparam logic [4:0] LAST_CNAME = 5'd24;

    // Header field positions
    localparam logic [3:0] HDR_LEN = 4'd12;
    localparam logic [3:0] ID_LEN  = 4'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_TTL     = 2'd0;
    localparam logic [1:0] CFG_IPV4    = 2'd1;
    localparam logic [1:0] CFG_IPV6_HI = 2'd2;
    localparam logic [1:0] CFG_IPV6_LO = 2'd3;

    // Configuration reset values
    localparam logic [31:0] TTL_RESET     = 32'h0000_0E10;
    localparam logic [31:0] IPV4_RESET    = 32'hC000_0201;
    localparam logic [63:0] IPV6_HI_RESET = 64'h2001_0DB8_0000_0000;
    localparam logic [63:0] IPV6_LO_RESET = 64'h0000_0000_0000_0001;

    // Struct from parser to top: what one accepted byte produces
    typedef struct packed {
        logic       emit;
        reply_t     reply;
        logic       start_answer;
        logic [1:0] kind;
    } parse_res_t;

    // Fixed header bytes: flags 8000, counts 1,1,0,0
    function automatic logic [7:0] header_byte(input logic [3:0] pos);
        logic [7:0] b;
        begin
            case (pos)
                4'd2:    b = 8'h80;
                4'd5:    b = 8'h01;
                4'd7:    b = 8'h01;
                default: b = 8'h00;
            endcase
            return b;
        end
    endfunction

    // Encoded name example.com
    function automatic logic [7:0] cname_byte(input logic [3:0] pos);
        logic [7:0] b;
        begin
            case (pos)
                4'd0:    b = 8'h07;
                4'd1:    b = 8'h65;
                4'd2:    b = 8'h78;
                4'd3:    b = 8'h61;
                4'd4:    b = 8'h6D;
                4'd5:    b = 8'h70;
                4'd6:    b = 8'h6C;
                4'd7:    b = 8'h65;
                4'd8:    b = 8'h03;
                4'd9:    b = 8'h63;
                4'd10:   b = 8'h6F;
                4'd11:   b = 8'h6D;
                default: b = 8'h00;
            endcase
            return b;
        end
    endfunction

endpackage

[src/dns_query_responder_top.sv]
// DNS query responder top: config registers, parser, answer sequencer and
// the reply output register. Uses dqr_pkg, dqr_parser, dqr_answer.
// The reply byte is registered: it is valid in the cycle after its query byte transfer.
// Throughput: one query byte per cycle while the output slot is free; each query
// byte gives at most one reply byte, except the final class byte of a served type,
// after which the answer sequencer holds query_ready low while it drives the 16-byte
// (A), 28-byte (AAAA) or 25-byte (CNAME) record, and longer while reply_ready stalls it.
// Reset clears parse state and the output valid and loads the default TTL and addresses.
module dns_query_responder_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            query_valid,
    output logic            query_ready,
    input  dqr_pkg::query_t query,
    output logic            reply_valid,
    input  logic            reply_ready,
    output dqr_pkg::reply_t reply,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic [63:0]     cfg_wdata
);

    logic [31:0]         ttl_reg;
    logic [31:0]         ipv4_reg;
    logic [63:0]         ipv6_hi_reg;
    logic [63:0]         ipv6_lo_reg;
    logic                out_valid_reg;
    dqr_pkg::reply_t     out_data_reg;
    logic                slot_free;
    logic                accept;
    logic                ans_active;
    dqr_pkg::reply_t     ans_reply;
    dqr_pkg::parse_res_t pres;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ttl_reg     <= dqr_pkg::TTL_RESET;
            ipv4_reg    <= dqr_pkg::IPV4_RESET;
            ipv6_hi_reg <= dqr_pkg::IPV6_HI_RESET;
            ipv6_lo_reg <= dqr_pkg::IPV6_LO_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dqr_pkg::CFG_TTL:     ttl_reg     <= cfg_wdata[31:0];
                dqr_pkg::CFG_IPV4:    ipv4_reg    <= cfg_wdata[31:0];
                dqr_pkg::CFG_IPV6_HI: ipv6_hi_reg <= cfg_wdata;
                dqr_pkg::CFG_IPV6_LO: ipv6_lo_reg <= cfg_wdata;
                default:              ttl_reg     <= ttl_reg;
            endcase
        end
    end

    // Take a query byte when the output slot frees and no record is running
    assign slot_free   = !out_valid_reg || reply_ready;
    assign query_ready = slot_free && !ans_active;
    assign accept      = query_valid && query_ready;

    dqr_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .query  (query),
        .res    (pres)
    );

    dqr_answer u_answer (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (accept && pres.start_answer),
        .kind             (pres.kind),
        .advance          (slot_free),
        .answer_ttl       (ttl_reg),
        .ipv4_answer      (ipv4_reg),
        .ipv6_answer_high (ipv6_hi_reg),
        .ipv6_answer_low  (ipv6_lo_reg),
        .active           (ans_active),
        .reply            (ans_reply)
    );

    // Load the output register from the sequencer or the parser
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (slot_free)
            out_valid_reg <= ans_active || (accept && pres.emit);
    end

    always_ff @(posedge clk)
    begin
        if (slot_free)
        begin
            if (ans_active)
                out_data_reg <= ans_reply;
            else if (accept && pres.emit)
                out_data_reg <= pres.reply;
        end
    end

    assign reply_valid = out_valid_reg;
    assign reply       = out_data_reg;

    // Input stalls for the whole answer record
    a_stall_in_answer: assert property (@(posedge clk) disable iff (!rst_n)
        ans_active |-> !query_ready)
        else $error("query accepted during answer record");

    // A served class byte is followed by the record start
    a_answer_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && pres.start_answer |=> ans_active)
        else $error("answer record did not start");

    // A drop status only appears on the final byte
    a_status_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        reply_valid && reply.reply_status != dqr_pkg::ST_ANSWERED
        |-> reply.reply_last)
        else $error("drop status on a non-final byte");

    // A served class byte is never itself the final byte
    a_start_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && pres.start_answer |=> reply_valid && !reply.reply_last)
        else $error("class byte marked final before answer");

endmodule

[src/dqr_parser.sv]
// Query parser: walks header, name labels, QTYPE and QCLASS one byte per
// transfer and decides the reply byte and answer start. Uses dqr_pkg.
module dqr_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  dqr_pkg::query_t     query,
    output dqr_pkg::parse_res_t res
);

    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  fpos_reg, fpos_next;
    logic [7:0]  label_left_reg, label_left_next;
    logic [15:0] ctype_reg, ctype_next;

    // Decode one byte against the current phase
    always_comb
    begin
        logic [7:0]  b;
        logic        done;
        logic [3:0]  fp;
        logic [15:0] t;
        b    = query.query_byte;
        done = 1'b0;
        fp   = 4'd0;
        t    = 16'd0;

        res                     = '0;
        phase_next              = phase_reg;
        fpos_next               = fpos_reg;
        label_left_next         = label_left_reg;
        ctype_next              = ctype_reg;

        case (phase_reg)
            dqr_pkg::PH_NAME:
            begin
                res.emit             = 1'b1;
                res.reply.reply_byte = b;
                if (b == 8'd0)
                begin
                    phase_next = dqr_pkg::PH_TYPE;
                    fpos_next  = 4'd0;
                end
                else
                begin
                    label_left_next = b;
                    phase_next      = dqr_pkg::PH_LABEL;
                end
            end
            dqr_pkg::PH_LABEL:
            begin
                res.emit             = 1'b1;
                res.reply.reply_byte = b;
                label_left_next      = label_left_reg - 8'd1;
                if (label_left_next == 8'd0)
                    phase_next = dqr_pkg::PH_NAME;
            end
            dqr_pkg::PH_TYPE:
            begin
                res.emit             = 1'b1;
                res.reply.reply_byte = b;
                ctype_next           = {ctype_reg[7:0], b};
                fpos_next            = fpos_reg + 4'd1;
                if (fpos_next >= 4'd2)
                begin
                    phase_next = dqr_pkg::PH_CLASS;
                    fpos_next  = 4'd0;
                end
            end
            dqr_pkg::PH_CLASS:
            begin
                res.emit             = 1'b1;
                res.reply.reply_byte = b;
                fpos_next            = fpos_reg + 4'd1;
                if (fpos_next >= 4'd2)
                begin
                    // Final class byte: answer or close with unsupported
                    done = 1'b1;
                    t    = ctype_reg;
                    if (t == dqr_pkg::QTYPE_A || t == dqr_pkg::QTYPE_AAAA ||
                        t == dqr_pkg::QTYPE_CNAME)
                    begin
                        res.start_answer = 1'b1;
                        if (t == dqr_pkg::QTYPE_A)
                            res.kind = dqr_pkg::ANS_A;
                        else if (t == dqr_pkg::QTYPE_AAAA)
                            res.kind = dqr_pkg::ANS_AAAA;
                        else
                            res.kind = dqr_pkg::ANS_CNAME;
                    end
                    else
                    begin
                        res.reply.reply_last   = 1'b1;
                        res.reply.reply_status = dqr_pkg::ST_UNSUPPORTED;
                    end
                    phase_next      = query.datagram_end ? dqr_pkg::PH_HEADER
                                                         : dqr_pkg::PH_DISCARD;
                    fpos_next       = 4'd0;
                    label_left_next = 8'd0;
                    ctype_next      = 16'd0;
                end
            end
            dqr_pkg::PH_DISCARD:
            begin
                // Drop trailing records until the datagram ends
                done = 1'b1;
                if (query.datagram_end)
                begin
                    phase_next      = dqr_pkg::PH_HEADER;
                    fpos_next       = 4'd0;
                    label_left_next = 8'd0;
                    ctype_next      = 16'd0;
                end
            end
            default:
            begin
                // Header: copy ID, then fixed flags and counts
                fp = (fpos_reg >= dqr_pkg::HDR_LEN) ? 4'd0 : fpos_reg;
                res.emit             = 1'b1;
                res.reply.reply_byte = (fp < dqr_pkg::ID_LEN) ? b
                                                              : dqr_pkg::header_byte(fp);
                fp = fp + 4'd1;
                if (fp >= dqr_pkg::HDR_LEN)
                begin
                    phase_next = dqr_pkg::PH_NAME;
                    fpos_next  = 4'd0;
                end
                else
                begin
                    phase_next = dqr_pkg::PH_HEADER;
                    fpos_next  = fp;
                end
            end
        endcase

        // Early end inside header or question: close as malformed
        if (!done && query.datagram_end)
        begin
            res.reply.reply_last   = 1'b1;
            res.reply.reply_status = dqr_pkg::ST_MALFORMED;
            phase_next             = dqr_pkg::PH_HEADER;
            fpos_next              = 4'd0;
            label_left_next        = 8'd0;
            ctype_next             = 16'd0;
        end
    end

    // Advance parse state on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= dqr_pkg::PH_HEADER;
            fpos_reg       <= 4'd0;
            label_left_reg <= 8'd0;
            ctype_reg      <= 16'd0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            fpos_reg       <= fpos_next;
            label_left_reg <= label_left_next;
            ctype_reg      <= ctype_next;
        end
    end

    // A label in progress always has bytes left to copy
    a_label_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == dqr_pkg::PH_LABEL |-> label_left_reg != 8'd0)
        else $error("label phase with zero bytes left");

endmodule

[src/dqr_answer.sv]
// Answer record sequencer: emits pointer, type, class, TTL, RDLENGTH and
// RDATA one byte per output slot. Uses dqr_pkg.
module dqr_answer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [1:0]      kind,
    input  logic            advance,
    input  logic [31:0]     answer_ttl,
    input  logic [31:0]     ipv4_answer,
    input  logic [63:0]     ipv6_answer_high,
    input  logic [63:0]     ipv6_answer_low,
    output logic            active,
    output dqr_pkg::reply_t reply
);

    logic       active_reg, active_next;
    logic [4:0] idx_reg, idx_next;
    logic [1:0] kind_reg, kind_next;
    logic [4:0] last_idx;
    logic [4:0] r;
    logic [7:0] b;

    // Select final byte index for the record kind
    always_comb
    begin
        case (kind_reg)
            dqr_pkg::ANS_A:    last_idx = dqr_pkg::LAST_A;
            dqr_pkg::ANS_AAAA: last_idx = dqr_pkg::LAST_AAAA;
            default:           last_idx = dqr_pkg::LAST_CNAME;
        endcase
    end

    // Pick the byte at the current index
    assign r = idx_reg - 5'd12;

    always_comb
    begin
        case (idx_reg)
            5'd0:  b = 8'hC0;
            5'd1:  b = 8'h0C;
            5'd2:  b = 8'h00;
            5'd3:
            begin
                case (kind_reg)
                    dqr_pkg::ANS_A:    b = dqr_pkg::QTYPE_A[7:0];
                    dqr_pkg::ANS_AAAA: b = dqr_pkg::QTYPE_AAAA[7:0];
                    default:           b = dqr_pkg::QTYPE_CNAME[7:0];
                endcase
            end
            5'd4:  b = 8'h00;
            5'd5:  b = 8'h01;
            5'd6:  b = answer_ttl[31:24];
            5'd7:  b = answer_ttl[23:16];
            5'd8:  b = answer_ttl[15:8];
            5'd9:  b = answer_ttl[7:0];
            5'd10: b = 8'h00;
            5'd11:
            begin
                case (kind_reg)
                    dqr_pkg::ANS_A:    b = 8'h04;
                    dqr_pkg::ANS_AAAA: b = 8'h10;
                    default:           b = 8'h0D;
                endcase
            end
            default:
            begin
                case (kind_reg)
                    dqr_pkg::ANS_A:
                        b = ipv4_answer[{~r[1:0], 3'b000} +: 8];
                    dqr_pkg::ANS_AAAA:
                        b = r[3] ? ipv6_answer_low[{~r[2:0], 3'b000} +: 8]
                                 : ipv6_answer_high[{~r[2:0], 3'b000} +: 8];
                    default:
                        b = dqr_pkg::cname_byte(r[3:0]);
                endcase
            end
        endcase
    end

    always_comb
    begin
        reply.reply_byte   = b;
        reply.reply_last   = (idx_reg == last_idx);
        reply.reply_status = dqr_pkg::ST_ANSWERED;
    end

    // Start on the final class byte, advance per output slot, stop at end
    always_comb
    begin
        active_next = active_reg;
        idx_next    = idx_reg;
        kind_next   = kind_reg;
        if (start)
        begin
            active_next = 1'b1;
            idx_next    = 5'd0;
            kind_next   = kind;
        end
        else if (active_reg && advance)
        begin
            idx_next = idx_reg + 5'd1;
            if (idx_reg == last_idx)
                active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= 5'd0;
            kind_reg   <= dqr_pkg::ANS_A;
        end
        else
        begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
            kind_reg   <= kind_next;
        end
    end

    assign active = active_reg;

    // Index never runs past the record end
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> idx_reg <= last_idx)
        else $error("answer index beyond record end");

endmodule

[test/dns_query_responder_top_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for dns_query_responder_top: streams query bytes,
// predicts every reply byte and compares field by field. Depends on dqr_pkg.
module dns_query_responder_top_tb;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int          SETTLE_CYCLES = 40;

    // Fixed header bytes after the ID: flags 8000, counts 1,1,0,0
    localparam logic [95:0]  HDR_FIXED   = 96'h0000_8000_0001_0001_0000_0000;
    // Encoded name returned for CNAME answers
    localparam logic [103:0] EXAMPLE_COM = {8'h07, "example", 8'h03, "com", 8'h00};
    localparam logic [7:0]   RDLEN_A     = 8'd4;
    localparam logic [7:0]   RDLEN_AAAA  = 8'd16;
    localparam logic [7:0]   RDLEN_CNAME = 8'd13;

    // Kinds of generated queries
    localparam int Q_A           = 0;
    localparam int Q_AAAA        = 1;
    localparam int Q_CNAME       = 2;
    localparam int Q_OTHER       = 3;
    localparam int Q_HIGH_BYTE   = 4;
    localparam int Q_RANDOM      = -1;

    logic            clk;
    logic            rst_n       = 1'b0;
    logic            query_valid = 1'b0;
    logic            query_ready;
    dqr_pkg::query_t query       = '0;
    logic            reply_valid;
    logic            reply_ready = 1'b0;
    dqr_pkg::reply_t reply;
    logic            cfg_we      = 1'b0;
    logic [1:0]      cfg_index   = dqr_pkg::CFG_TTL;
    logic [63:0]     cfg_wdata   = '0;

    // Predictor state and register copies
    logic [2:0]  phase_now;
    logic [3:0]  field_idx;
    logic [7:0]  label_left;
    logic [15:0] seen_type;
    logic [31:0] ttl_cfg;
    logic [31:0] ipv4_cfg;
    logic [63:0] ipv6_hi_cfg;
    logic [63:0] ipv6_lo_cfg;

    dqr_pkg::query_t query_backlog[$];
    dqr_pkg::reply_t expected_replies[$];
    dqr_pkg::reply_t want;
    int          send_gap      = 0;
    int          stall_left    = 0;
    int          n_queued      = 0;
    int          n_replies     = 0;
    int          n_errors      = 0;
    int unsigned cycle_count   = 0;
    logic        calm          = 1'b0;

    dns_query_responder_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .query_valid (query_valid),
        .query_ready (query_ready),
        .query       (query),
        .reply_valid (reply_valid),
        .reply_ready (reply_ready),
        .reply       (reply),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("dns_query_responder_top_tb: done, errors");
            $finish;
        end
    end

    function automatic void rewind_parser();
        phase_now  = dqr_pkg::PH_HEADER;
        field_idx  = '0;
        label_left = '0;
        seen_type  = '0;
    endfunction

    // Work out the reply bytes caused by one query byte transfer
    task automatic predict_reply_bytes(input dqr_pkg::query_t q);
        logic [7:0]      b;
        logic [7:0]      bytes_out[$];
        logic            handled;
        logic            mark_last;
        logic [1:0]      status;
        dqr_pkg::reply_t r;
        int              i;
        b         = q.query_byte;
        handled   = 1'b0;
        mark_last = 1'b0;
        status    = dqr_pkg::ST_ANSWERED;
        case (phase_now)
            dqr_pkg::PH_NAME:
            begin
                bytes_out.push_back(b);
                if (b == 8'h00)
                begin
                    phase_now = dqr_pkg::PH_TYPE;
                    field_idx = '0;
                end
                else
                begin
                    label_left = b;
                    phase_now  = dqr_pkg::PH_LABEL;
                end
            end
            dqr_pkg::PH_LABEL:
            begin
                bytes_out.push_back(b);
                label_left = label_left - 8'd1;
                if (label_left == 8'd0)
                    phase_now = dqr_pkg::PH_NAME;
            end
            dqr_pkg::PH_TYPE:
            begin
                bytes_out.push_back(b);
                seen_type = {seen_type[7:0], b};
                field_idx = field_idx + 4'd1;
                if (field_idx >= 4'd2)
                begin
                    phase_now = dqr_pkg::PH_CLASS;
                    field_idx = '0;
                end
            end
            dqr_pkg::PH_CLASS:
            begin
                bytes_out.push_back(b);
                field_idx = field_idx + 4'd1;
                if (field_idx >= 4'd2)
                begin
                    handled   = 1'b1;
                    mark_last = 1'b1;
                    if (seen_type == dqr_pkg::QTYPE_A || seen_type == dqr_pkg::QTYPE_AAAA ||
                        seen_type == dqr_pkg::QTYPE_CNAME)
                    begin
                        // Append the answer record: pointer, type, class, TTL, RDLENGTH, RDATA
                        bytes_out.push_back(8'hC0);
                        bytes_out.push_back(8'h0C);
                        bytes_out.push_back(seen_type[15:8]);
                        bytes_out.push_back(seen_type[7:0]);
                        bytes_out.push_back(8'h00);
                        bytes_out.push_back(8'h01);
                        for (i = 3; i >= 0; i--)
                            bytes_out.push_back(ttl_cfg[8*i +: 8]);
                        bytes_out.push_back(8'h00);
                        if (seen_type == dqr_pkg::QTYPE_A)
                        begin
                            bytes_out.push_back(RDLEN_A);
                            for (i = 3; i >= 0; i--)
                                bytes_out.push_back(ipv4_cfg[8*i +: 8]);
                        end
                        else if (seen_type == dqr_pkg::QTYPE_AAAA)
                        begin
                            bytes_out.push_back(RDLEN_AAAA);
                            for (i = 7; i >= 0; i--)
                                bytes_out.push_back(ipv6_hi_cfg[8*i +: 8]);
                            for (i = 7; i >= 0; i--)
                                bytes_out.push_back(ipv6_lo_cfg[8*i +: 8]);
                        end
                        else
                        begin
                            bytes_out.push_back(RDLEN_CNAME);
                            for (i = 0; i < 13; i++)
                                bytes_out.push_back(EXAMPLE_COM[103 - 8*i -: 8]);
                        end
                        status = dqr_pkg::ST_ANSWERED;
                    end
                    else
                        status = dqr_pkg::ST_UNSUPPORTED;
                    rewind_parser();
                    if (!q.datagram_end)
                        phase_now = dqr_pkg::PH_DISCARD;
                end
            end
            dqr_pkg::PH_DISCARD:
            begin
                // Swallow extra records until the datagram ends
                handled = 1'b1;
                if (q.datagram_end)
                    rewind_parser();
            end
            default:
            begin
                phase_now = dqr_pkg::PH_HEADER;
                if (field_idx >= 4'd12)
                    field_idx = '0;
                if (field_idx < 4'd2)
                    bytes_out.push_back(b);
                else
                    bytes_out.push_back(HDR_FIXED[95 - 8*int'(field_idx) -: 8]);
                field_idx = field_idx + 4'd1;
                if (field_idx >= 4'd12)
                begin
                    phase_now = dqr_pkg::PH_NAME;
                    field_idx = '0;
                end
            end
        endcase
        // Datagram ended inside the header or question
        if (!handled && q.datagram_end)
        begin
            mark_last = 1'b1;
            status    = dqr_pkg::ST_MALFORMED;
            rewind_parser();
        end
        for (i = 0; i < bytes_out.size(); i++)
        begin
            r.reply_byte   = bytes_out[i];
            r.reply_last   = mark_last && (i == bytes_out.size() - 1);
            r.reply_status = r.reply_last ? status : dqr_pkg::ST_ANSWERED;
            expected_replies.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] exp_val);
        n_errors++;
        $display("MISMATCH reply %0d %s: got %h, expected %h (t=%0t)",
                 n_replies, what, got, exp_val, $realtime);
    endtask

    // Drive query bytes from the backlog, with random idle bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_valid <= 1'b0;
            query       <= '0;
            send_gap    <= 0;
        end
        else
        begin
            if (query_valid && query_ready)
                predict_reply_bytes(query);
            if (!query_valid || query_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap    <= send_gap - 1;
                    query_valid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 9) == 0)
                begin
                    send_gap    <= $urandom_range(0, 13);
                    query_valid <= 1'b0;
                end
                else if (query_backlog.size() > 0)
                begin
                    query       <= query_backlog.pop_front();
                    query_valid <= 1'b1;
                end
                else
                    query_valid <= 1'b0;
            end
        end
    end

    // Check every reply transfer, with random stall bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reply_ready <= 1'b0;
            stall_left  <= 0;
        end
        else
        begin
            if (reply_valid && reply_ready)
            begin
                n_replies++;
                if (expected_replies.size() == 0)
                    report_mismatch("reply with none expected", reply.reply_byte, 8'h00);
                else
                begin
                    want = expected_replies.pop_front();
                    if (reply.reply_byte !== want.reply_byte)
                        report_mismatch("reply_byte", reply.reply_byte, want.reply_byte);
                    if (reply.reply_last !== want.reply_last)
                        report_mismatch("reply_last", 8'(reply.reply_last),
                                        8'(want.reply_last));
                    if (reply.reply_status !== want.reply_status)
                        report_mismatch("reply_status", 8'(reply.reply_status),
                                        8'(want.reply_status));
                end
            end
            if (stall_left > 0)
            begin
                stall_left  <= stall_left - 1;
                reply_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                stall_left  <= $urandom_range(0, 13);
                reply_ready <= 1'b0;
            end
            else
                reply_ready <= 1'b1;
        end
    end

    task automatic queue_byte(input logic [7:0] b, input logic last);
        dqr_pkg::query_t q;
        q.query_byte   = b;
        q.datagram_end = last;
        query_backlog.push_back(q);
        n_queued++;
    endtask

    // Build one query datagram; any may carry extra bytes, random ones may also be cut short
    task automatic queue_query(input int kind);
        logic [7:0]  msg[$];
        logic [15:0] qtype;
        logic [15:0] qclass;
        int          pick;
        int          labels;
        int          len;
        int          extra;
        int          cut;
        int          i;
        int          j;
        pick = kind;
        if (kind == Q_RANDOM)
        begin
            j = $urandom_range(0, 9);
            pick = (j < 3) ? Q_A : (j < 6) ? Q_AAAA : (j < 8) ? Q_CNAME :
                   (j == 8) ? Q_OTHER : Q_HIGH_BYTE;
        end
        for (i = 0; i < 12; i++)
            msg.push_back(8'($urandom));
        labels = $urandom_range(0, 3);
        for (i = 0; i < labels; i++)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
            msg.push_back(8'(len));
            for (j = 0; j < len; j++)
                msg.push_back(8'($urandom));
        end
        msg.push_back(8'h00);
        case (pick)
            Q_A:     qtype = dqr_pkg::QTYPE_A;
            Q_AAAA:  qtype = dqr_pkg::QTYPE_AAAA;
            Q_CNAME: qtype = dqr_pkg::QTYPE_CNAME;
            Q_OTHER: qtype = 16'($urandom);
            default:
            begin
                // Served low byte behind a nonzero high byte
                qtype[15:8] = 8'($urandom_range(1, 255));
                case ($urandom_range(0, 2))
                    0:       qtype[7:0] = dqr_pkg::QTYPE_A[7:0];
                    1:       qtype[7:0] = dqr_pkg::QTYPE_AAAA[7:0];
                    default: qtype[7:0] = dqr_pkg::QTYPE_CNAME[7:0];
                endcase
            end
        endcase
        qclass = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0001;
        msg.push_back(qtype[15:8]);
        msg.push_back(qtype[7:0]);
        msg.push_back(qclass[15:8]);
        msg.push_back(qclass[7:0]);
        extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        for (i = 0; i < extra; i++)
            msg.push_back(8'($urandom));
        cut = msg.size() - 1;
        if (kind == Q_RANDOM && $urandom_range(0, 4) == 0)
            cut = $urandom_range(0, msg.size() - 1);
        for (i = 0; i <= cut; i++)
            queue_byte(msg[i], i == cut);
    endtask

    // One query of a served type, then random queries up to the byte target
    task automatic queue_random_part(input int forced_kind, input int target);
        int start;
        start = n_queued;
        queue_query(forced_kind);
        while (n_queued - start < target)
            queue_query(Q_RANDOM);
    endtask

    // Hold until every byte has gone in and every reply has come out
    task automatic wait_idle();
        while (query_backlog.size() != 0 || query_valid || expected_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_settings(input logic [31:0] ttl, input logic [31:0] v4,
                                  input logic [63:0] hi, input logic [63:0] lo);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= dqr_pkg::CFG_TTL;
        cfg_wdata <= {32'($urandom), ttl};
        @(posedge clk);
        cfg_index <= dqr_pkg::CFG_IPV4;
        cfg_wdata <= {32'($urandom), v4};
        @(posedge clk);
        cfg_index <= dqr_pkg::CFG_IPV6_HI;
        cfg_wdata <= hi;
        @(posedge clk);
        cfg_index <= dqr_pkg::CFG_IPV6_LO;
        cfg_wdata <= lo;
        @(posedge clk);
        cfg_we      <= 1'b0;
        ttl_cfg     = ttl;
        ipv4_cfg    = v4;
        ipv6_hi_cfg = hi;
        ipv6_lo_cfg = lo;
    endtask

    initial
    begin
        int i;
        rewind_parser();
        ttl_cfg     = dqr_pkg::TTL_RESET;
        ipv4_cfg    = dqr_pkg::IPV4_RESET;
        ipv6_hi_cfg = dqr_pkg::IPV6_HI_RESET;
        ipv6_lo_cfg = dqr_pkg::IPV6_LO_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Datagram that ends on its first byte
        queue_byte(8'hA5, 1'b1);
        // Oversize label length, datagram ends inside the label
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b0);
        for (i = 0; i < 10; i++)
            queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b1);
        // Unsupported type with extra bytes after the question
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        for (i = 0; i < 10; i++)
            queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b0);
        for (i = 0; i < 4; i++)
            queue_byte(8'hFF, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'hFE, 1'b1);
        wait_idle();

        write_settings('0, '0, '0, '0);
        queue_random_part(Q_A, 24);
        wait_idle();

        write_settings('1, '1, '1, '1);
        queue_random_part(Q_AAAA, 16);
        wait_idle();

        // Last part runs at full rate on both sides
        write_settings($urandom, $urandom, {$urandom, $urandom}, {$urandom, $urandom});
        calm = 1'b1;
        queue_random_part(Q_CNAME, 16);
        wait_idle();

        if (n_errors == 0)
            $display("dns_query_responder_top_tb: done, clean");
        else
            $display("dns_query_responder_top_tb: done, errors");
        $finish;
    end

endmodule

[sim.f]
src/dqr_pkg.sv
src/dqr_parser.sv
src/dqr_answer.sv
src/dns_query_responder_top.sv
test/dns_query_responder_top_tb.sv
